### hw/rtl/mpct_pkg.sv
// Package for the mouse packet cursor tracker: widths, register indexes,
// the move command that passes from the framer to the mover, and config.
// No dependencies.
package mpct_pkg;

  localparam int ByteW   = 8;
  localparam int CoordW  = 12;
  localparam int StepW   = 8;
  localparam int BtnW    = 3;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 12;

  // Depth of the command queue between framer and mover.
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_STEP_SIZE     = 2'd2;

  // Reset values of the registers.
  localparam logic [CoordW-1:0] ScreenWidthRst  = 12'd1024;
  localparam logic [CoordW-1:0] ScreenHeightRst = 12'd768;
  localparam logic [StepW-1:0]  StepSizeRst     = 8'd2;

  // Status byte bits.
  localparam int BitFirstMark = 3;
  localparam int BitXNeg      = 4;
  localparam int BitYNeg      = 5;
  localparam int BitXOvf      = 6;
  localparam int BitYOvf      = 7;

  // The cursor stays this far from the far edge of the screen.
  localparam int EdgeMargin = 10;

  // Direction of a move on one axis.
  typedef enum logic [1:0] {
    MOVE_NONE = 2'd0,
    MOVE_INC  = 2'd1,
    MOVE_DEC  = 2'd2
  } move_e;

  // One decoded packet.
  typedef struct packed {
    logic [BtnW-1:0] buttons;
    move_e           move_x;
    move_e           move_y;
  } move_cmd_t;

  // Current register values.
  typedef struct packed {
    logic [CoordW-1:0] screen_width;
    logic [CoordW-1:0] screen_height;
    logic [StepW-1:0]  step_size;
  } cfg_t;

endpackage

### hw/rtl/mpct_byte_if.sv
// Channel for raw mouse bytes.
// Depends on mpct_pkg.
interface mpct_byte_if;
  logic                      valid;
  logic                      ready;
  logic [mpct_pkg::ByteW-1:0] mouse_byte;

  modport source (output valid, output mouse_byte, input ready);
  modport sink   (input valid, input mouse_byte, output ready);
endinterface

### hw/rtl/mpct_cursor_if.sv
// Channel for cursor results.
// Depends on mpct_pkg.
interface mpct_cursor_if;
  logic                        valid;
  logic                        ready;
  logic [mpct_pkg::CoordW-1:0] cursor_x;
  logic [mpct_pkg::CoordW-1:0] cursor_y;
  logic [mpct_pkg::BtnW-1:0]   buttons;

  modport source (output valid, output cursor_x, output cursor_y, output buttons, input ready);
  modport sink   (input valid, input cursor_x, input cursor_y, input buttons, output ready);
endinterface

### hw/rtl/mpct_framer.sv
// Front end: frames raw mouse bytes into 3-byte packets and turns each
// packet without overflow into a move command. Depends on mpct_pkg, mpct_byte_if.
module mpct_framer (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  mpct_byte_if.sink              byte_in,
  input  logic                   queue_full_i,
  output logic                   push_o,
  output mpct_pkg::move_cmd_t    cmd_o
);
  import mpct_pkg::*;

  localparam logic [1:0] IdxStatus = 2'd0;
  localparam logic [1:0] IdxDx     = 2'd1;
  localparam logic [1:0] IdxDy     = 2'd2;

  logic [1:0]       byte_idx_q, byte_idx_d;
  logic [ByteW-1:0] status_q, status_d;
  logic [ByteW-1:0] dx_q, dx_d;
  logic             accept;
  logic [ByteW-1:0] b;

  assign byte_in.ready = !queue_full_i;
  assign accept        = byte_in.valid && byte_in.ready;
  assign b             = byte_in.mouse_byte;

  // Packet framing.
  always_comb begin
    byte_idx_d = byte_idx_q;
    status_d   = status_q;
    dx_d       = dx_q;
    push_o     = 1'b0;
    if (accept) begin
      case (byte_idx_q)
        IdxStatus: begin
          if (b[BitFirstMark]) begin
            status_d   = b;
            byte_idx_d = IdxDx;
          end
        end
        IdxDx: begin
          dx_d       = b;
          byte_idx_d = IdxDy;
        end
        IdxDy: begin
          byte_idx_d = IdxStatus;
          push_o     = !(status_q[BitXOvf] || status_q[BitYOvf]);
        end
        default: byte_idx_d = IdxStatus;
      endcase
    end
  end

  // Decode each axis direction from the sign and whether the delta is nonzero.
  always_comb begin
    cmd_o.buttons = status_q[BtnW-1:0];
    if (status_q[BitXNeg]) begin
      cmd_o.move_x = MOVE_DEC;
    end else if (dx_q != '0) begin
      cmd_o.move_x = MOVE_INC;
    end else begin
      cmd_o.move_x = MOVE_NONE;
    end
    // Rows grow downward, so a positive dy moves the cursor up.
    if (status_q[BitYNeg]) begin
      cmd_o.move_y = MOVE_INC;
    end else if (b != '0) begin
      cmd_o.move_y = MOVE_DEC;
    end else begin
      cmd_o.move_y = MOVE_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_idx_q <= IdxStatus;
    end else begin
      byte_idx_q <= byte_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    dx_q     <= dx_d;
  end

  a_idx_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_idx_q != 2'd3)
    else $error("framer byte index out of range");

  a_push_third: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> accept && byte_idx_q == IdxDy)
    else $error("command pushed outside the third byte");

  a_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && byte_idx_q == IdxDy |=> byte_idx_q == IdxStatus)
    else $error("framer did not return to the status byte");

endmodule

### hw/rtl/mpct_cmd_fifo.sv
// Short queue of move commands between the framer and the mover.
// Depends on mpct_pkg.
module mpct_cmd_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  mpct_pkg::move_cmd_t    push_cmd_i,
  output logic                   full_o,
  input  logic                   pop_i,
  output logic                   empty_o,
  output mpct_pkg::move_cmd_t    pop_cmd_o
);
  import mpct_pkg::*;

  move_cmd_t             entry_q [QueueDepth];
  logic [QueuePtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0]  count_q, count_d;

  assign full_o    = count_q == QueueCntW'(QueueDepth);
  assign empty_o   = count_q == '0;
  assign pop_cmd_o = entry_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage needs no reset: an entry is read only after it was written.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into a full command queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from an empty command queue");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count did not grow on push");

endmodule

### hw/rtl/mpct_mover.sv
// Back end: applies move commands to the cursor, clamps it to the screen
// and holds the result word. Depends on mpct_pkg, mpct_cursor_if.
module mpct_mover (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mpct_pkg::cfg_t         cfg_i,
  input  logic                   empty_i,
  input  mpct_pkg::move_cmd_t    cmd_i,
  output logic                   pop_o,
  mpct_cursor_if.source          cursor_out
);
  import mpct_pkg::*;

  localparam int PosW = CoordW + 2;

  logic [CoordW-1:0] col_q, col_d;
  logic [CoordW-1:0] row_q, row_d;
  logic [BtnW-1:0]   btn_q, btn_d;
  logic              valid_q, valid_d;

  // Step one axis by the signed move, then clamp to 0 .. resolution - 10.
  function automatic logic [CoordW-1:0] move_clamp(
    input logic [CoordW-1:0] pos,
    input move_e             dir,
    input logic [StepW-1:0]  step,
    input logic [CoordW-1:0] res
  );
    logic signed [PosW-1:0] p;
    logic signed [PosW-1:0] s;
    logic [CoordW-1:0]      limit;
    s = $signed({{(PosW-StepW){1'b0}}, step});
    p = $signed({2'b00, pos});
    case (dir)
      MOVE_INC: p = p + s;
      MOVE_DEC: p = p - s;
      default:  p = p;
    endcase
    if (res < CoordW'(EdgeMargin)) begin
      limit = '0;
    end else begin
      limit = res - CoordW'(EdgeMargin);
    end
    if (p < 0) begin
      return '0;
    end else if (p > $signed({2'b00, limit})) begin
      return limit;
    end else begin
      return p[CoordW-1:0];
    end
  endfunction

  // Take a command whenever the result word is free or being taken.
  assign pop_o = !empty_i && (!valid_q || cursor_out.ready);

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    btn_d   = btn_q;
    valid_d = valid_q && !cursor_out.ready;
    if (pop_o) begin
      col_d   = move_clamp(col_q, cmd_i.move_x, cfg_i.step_size, cfg_i.screen_width);
      row_d   = move_clamp(row_q, cmd_i.move_y, cfg_i.step_size, cfg_i.screen_height);
      btn_d   = cmd_i.buttons;
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      btn_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      btn_q   <= btn_d;
      valid_q <= valid_d;
    end
  end

  assign cursor_out.valid    = valid_q;
  assign cursor_out.cursor_x = col_q;
  assign cursor_out.cursor_y = row_q;
  assign cursor_out.buttons  = btn_q;

  a_pop_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> valid_q)
    else $error("popped command produced no word");

  a_hold_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pop_o |=> $stable(col_q) && $stable(row_q) && $stable(btn_q))
    else $error("cursor changed without a command");

  a_pop_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !valid_q || cursor_out.ready)
    else $error("command taken while a word is still held");

endmodule

### hw/rtl/mouse_packet_cursor_tracker.sv
// Mouse packet cursor tracker, top level: register file, framer, queue, mover.
// Path: on a packet's third byte the framer pushes a command into the queue; the
// mover moves it into the result word register once that word is free or taken.
// Throughput: one byte per cycle until stalls fill the two-entry command queue.
// Reset: asynchronous, active low; cursor and buttons to 0, framing restarts at a
// status byte, registers to 1024, 768 and 2. No clearing pass is needed.
// Depends on mpct_pkg, mpct_byte_if, mpct_cursor_if and the mpct_* modules.
module mouse_packet_cursor_tracker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  mpct_byte_if.sink                     byte_in,
  mpct_cursor_if.source                 cursor_out,
  input  logic                          cfg_we_i,
  input  logic [mpct_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mpct_pkg::CfgW-1:0]     cfg_data_i
);
  import mpct_pkg::*;

  cfg_t      cfg_q;
  logic      push;
  logic      pop;
  logic      queue_full;
  logic      queue_empty;
  move_cmd_t push_cmd;
  move_cmd_t pop_cmd;

  // Configuration registers; writes beyond the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_width  <= ScreenWidthRst;
      cfg_q.screen_height <= ScreenHeightRst;
      cfg_q.step_size     <= StepSizeRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data_i[CoordW-1:0];
        CFG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data_i[CoordW-1:0];
        CFG_STEP_SIZE:     cfg_q.step_size     <= cfg_data_i[StepW-1:0];
        default:           cfg_q               <= cfg_q;
      endcase
    end
  end

  mpct_framer u_framer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_in      (byte_in),
    .queue_full_i (queue_full),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  mpct_cmd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (queue_full),
    .pop_i      (pop),
    .empty_o    (queue_empty),
    .pop_cmd_o  (pop_cmd)
  );

  mpct_mover u_mover (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .empty_i    (queue_empty),
    .cmd_i      (pop_cmd),
    .pop_o      (pop),
    .cursor_out (cursor_out)
  );

endmodule
